// ===== rtl/core/shec_pkg.sv =====
// Package for the SIEVE-style cache directory: constants, types, sequencer states.
`timescale 1ns / 1ps
package shec_pkg;
    localparam int unsigned ENTRIES_DEF = 64;
    localparam int unsigned CAP_W       = 7;
    localparam int unsigned KEY_W       = 32;
    localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

    localparam logic OP_ACCESS = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    typedef enum logic [4:0] {
        S_IDLE,
        S_SCAN,      // search for key, read slot i
        S_SCAN_W,    // compare read data
        S_HITRD,     // hit: read links of found slot
        S_HITUP,     // hit: unlink / push head / set visited
        S_UNL_H,     // unlink: fix head-side neighbor
        S_UNL_T,     // unlink: fix tail-side neighbor
        S_PUSH,      // push head: fix old head
        S_EV_CHK,    // eviction check
        S_EV_RD,     // read walk position
        S_EV_W,      // walk decide
        S_FREE_SCAN, // find lowest free slot
        S_FREE_W,
        S_INS,       // read old head links
        S_INS_W,     // write old head's toward_head
        S_OUT
    } t_state;

    typedef enum logic [1:0] {
        K_NONE,
        K_REMOVE,
        K_HIT,
        K_EVICT
    } t_after;
endpackage

// ===== rtl/core/shec_ram.sv =====
// Generic single-port synchronous RAM with registered read.
`timescale 1ns / 1ps
module shec_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

// ===== rtl/core/sieve_hand_eviction_cache.sv =====
// Timing: the key search reads and compares each slot in turn (S_SCAN, S_SCAN_W), then
// the list is updated; an access miss adds a search for the lowest free slot, and on a
// full directory also a hand walk and the unlink of each victim. Throughput is one
// word at a time; the next word is taken only after the result is accepted.
// Reset: synchronous active low; clears valid/visited/survived flags, list pointers,
// counters and capacity (to 64). No clearing pass is needed.
`timescale 1ns / 1ps
module sieve_hand_eviction_cache
    import shec_pkg::*;
#(
    parameter int unsigned ENTRIES = ENTRIES_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [CAP_W-1:0] i_capacity,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic             i_opcode,
    input  logic [KEY_W-1:0] i_key,
    output logic             o_valid,
    input  logic             i_ready,
    output logic             o_hit,
    output logic             o_evicted,
    output logic [KEY_W-1:0] o_evicted_key
);
    localparam int unsigned IW = $clog2(ENTRIES) + 1;  // index incl. null
    localparam int unsigned AW = $clog2(ENTRIES);
    localparam int unsigned LW = 2 * IW;
    localparam logic [IW-1:0] NIL = IW'(ENTRIES);

    // flag arrays (valid bits with reset)
    logic [ENTRIES-1:0] r_vld, r_vis, r_srv;

    // slot key memory and link memory {toward_head, toward_tail}
    logic          km_we, lm_we;
    logic [AW-1:0] km_addr, lm_addr;
    logic [KEY_W-1:0] km_wd, km_rd;
    logic [LW-1:0] lm_wd, lm_rd;

    shec_ram #(.WIDTH(KEY_W), .DEPTH(ENTRIES)) u_key_ram (
        .i_clk(i_clk), .i_we(km_we), .i_addr(km_addr), .i_wdata(km_wd), .o_rdata(km_rd));
    shec_ram #(.WIDTH(LW), .DEPTH(ENTRIES)) u_link_ram (
        .i_clk(i_clk), .i_we(lm_we), .i_addr(lm_addr), .i_wdata(lm_wd), .o_rdata(lm_rd));

    t_state r_state, n_state;
    t_after r_after, n_after;
    logic [CAP_W-1:0] r_cap;
    logic r_op;
    logic [KEY_W-1:0] r_key;
    logic [IW-1:0] r_head, r_tail, r_hand, n_head, n_tail, n_hand;
    logic [IW-1:0] r_pc, r_hc, r_ec, n_pc, n_hc, n_ec;
    logic [IW-1:0] r_i, n_i;       // scan index / slot under work
    logic [IW-1:0] r_lh, r_lt, n_lh, n_lt; // links of slot under work
    logic [IW-1:0] r_p, n_p;       // walk position
    logic r_hit, n_hit, r_ev, n_ev;
    logic [KEY_W-1:0] r_evk, n_evk;
    logic [IW-1:0] cap_eff;
    logic [ENTRIES-1:0] n_vld, n_vis, n_srv;
    logic [AW-1:0] ia, pa;
    logic [IW-1:0] rd_h, rd_t, walk_p, pc1, hc1;
    logic walk_restart, p_live;

    assign ia   = r_i[AW-1:0];
    assign pa   = r_p[AW-1:0];
    assign rd_h = lm_rd[LW-1:IW];
    assign rd_t = lm_rd[IW-1:0];

    // effective capacity
    always_comb begin
        if (r_cap == '0) cap_eff = IW'(1);
        else if (IW'(r_cap) > NIL || (CAP_W > IW && (r_cap >> IW) != '0)) cap_eff = NIL;
        else cap_eff = IW'(r_cap);
    end

    // a capacity write goes first when both channels offer a word
    assign o_ready     = (r_state == S_IDLE) && !i_cfg_valid;
    assign o_cfg_ready = (r_state == S_IDLE) && !o_valid;
    assign o_valid     = (r_state == S_OUT);
    assign o_hit       = r_hit;
    assign o_evicted   = r_ev;
    assign o_evicted_key = r_evk;

    function automatic logic live(input logic [IW-1:0] x, input logic [ENTRIES-1:0] v);
        live = (x < NIL) && v[x[AW-1:0]];
    endfunction

    // walk step values
    always_comb begin
        pc1 = r_pc + IW'(1);
        hc1 = r_srv[pa] ? r_hc : r_hc + IW'(1);
        walk_p = rd_h;
        walk_restart = (pc1 >= r_ec) || ((r_ec - pc1) <= (hc1 >> 1)) || !live(rd_h, r_vld);
        p_live = live(r_p, r_vld);
    end

    // next state and datapath
    always_comb begin
        n_state = r_state; n_after = r_after;
        n_head = r_head; n_tail = r_tail; n_hand = r_hand;
        n_pc = r_pc; n_hc = r_hc; n_ec = r_ec;
        n_i = r_i; n_lh = r_lh; n_lt = r_lt; n_p = r_p;
        n_hit = r_hit; n_ev = r_ev; n_evk = r_evk;
        n_vld = r_vld; n_vis = r_vis; n_srv = r_srv;
        km_we = 1'b0; km_addr = ia; km_wd = r_key;
        lm_we = 1'b0; lm_addr = ia; lm_wd = {r_lh, r_lt};
        unique case (r_state)
            S_IDLE: begin
                if (i_valid && o_ready) begin
                    n_i = '0; n_hit = 1'b0; n_ev = 1'b0; n_evk = '0;
                    n_after = K_NONE;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                km_addr = ia;
                n_state = S_SCAN_W;
            end
            S_SCAN_W: begin
                if (r_vld[ia] && km_rd == r_key) begin
                    n_hit = 1'b1;
                    n_state = S_HITRD;
                end else if (r_i == NIL - IW'(1)) begin
                    if (r_op == OP_REMOVE) n_state = S_OUT;
                    else n_state = S_EV_CHK;
                end else begin
                    n_i = r_i + IW'(1);
                    n_state = S_SCAN;
                end
            end
            S_HITRD: begin
                lm_addr = ia;
                n_state = S_HITUP;
            end
            S_HITUP: begin
                n_lh = rd_h; n_lt = rd_t;
                if (r_op == OP_REMOVE) begin
                    if (r_hand == r_i) n_hand = rd_h;
                    n_vld[ia] = 1'b0; n_vis[ia] = 1'b0; n_srv[ia] = 1'b0;
                    if (r_ec != '0) n_ec = r_ec - IW'(1);
                    n_after = K_REMOVE;
                    n_state = S_UNL_H;
                end else begin
                    n_vis[ia] = 1'b1;
                    if (!r_srv[ia]) begin
                        if (r_hand == r_i) n_hand = rd_h;
                        n_after = K_HIT;
                        n_state = S_UNL_H;
                    end else begin
                        n_state = S_OUT;
                    end
                end
            end
            // unlink r_i (links in r_lh / r_lt)
            S_UNL_H: begin
                if (r_lh < NIL) begin
                    lm_addr = r_lh[AW-1:0];
                    n_state = S_UNL_T;
                    n_p = r_lh;
                end else begin
                    n_head = r_lt;
                    n_p = NIL;
                    n_state = S_UNL_T;
                end
            end
            S_UNL_T: begin
                // write head neighbor's toward_tail, preserving its toward_head
                if (r_p < NIL) begin
                    lm_we = 1'b1; lm_addr = pa; lm_wd = {rd_h, r_lt};
                    n_p = NIL;
                    n_state = S_UNL_T;
                end else if (r_lt < NIL) begin
                    lm_addr = r_lt[AW-1:0];
                    n_p = r_lt;
                    n_lt = NIL;  // mark done; tail side read issued
                    n_state = S_PUSH;
                end else begin
                    n_tail = r_lh;
                    n_state = S_PUSH;
                end
                if (r_p < NIL) n_state = S_UNL_T;
            end
            S_PUSH: begin
                // finish tail neighbor update if one was read
                if (r_p < NIL) begin
                    lm_we = 1'b1; lm_addr = pa; lm_wd = {r_lh, rd_t};
                    n_p = NIL;
                end else if (r_after == K_HIT) begin
                    // push r_i at head: write own links, fix old head
                    lm_we = 1'b1; lm_addr = ia;
                    lm_wd = {NIL, (r_head == r_i) ? NIL : r_head};
                    n_lh = NIL; n_lt = (r_head == r_i) ? NIL : r_head;
                    n_p = n_lt; n_after = K_NONE;
                    n_head = r_i;
                    if (n_lt == NIL) n_tail = r_i;
                    n_state = S_INS;
                end else if (r_after == K_REMOVE) begin
                    n_state = S_OUT;
                end else begin
                    n_after = K_NONE;
                    n_state = S_EV_CHK;
                end
            end
            S_EV_CHK: begin
                if (r_ec >= cap_eff) begin
                    n_p = r_hand;
                    if (!live(r_hand, r_vld)) begin
                        n_p = r_tail; n_pc = '0; n_hc = '0;
                    end
                    n_state = S_EV_RD;
                end else begin
                    n_i = '0;
                    n_state = S_FREE_SCAN;
                end
            end
            S_EV_RD: begin
                if (!p_live) begin
                    n_i = '0;
                    n_state = S_FREE_SCAN;
                end else begin
                    lm_addr = pa; km_addr = pa;
                    n_state = S_EV_W;
                end
            end
            S_EV_W: begin
                if (r_vis[pa]) begin
                    n_vis[pa] = 1'b0;
                    n_srv[pa] = 1'b1;
                    if (walk_restart) begin
                        n_p = r_tail; n_pc = '0; n_hc = '0;
                    end else begin
                        n_p = walk_p; n_pc = pc1; n_hc = hc1;
                    end
                    n_state = S_EV_RD;
                end else begin
                    // evict p
                    if (!r_ev) begin
                        n_ev = 1'b1; n_evk = km_rd;
                    end
                    n_hand = rd_h;
                    n_i = r_p; n_lh = rd_h; n_lt = rd_t;
                    n_vld[pa] = 1'b0; n_vis[pa] = 1'b0; n_srv[pa] = 1'b0;
                    if (r_ec != '0) n_ec = r_ec - IW'(1);
                    n_after = K_EVICT;
                    n_p = NIL;
                    n_state = S_UNL_H;
                end
            end
            S_FREE_SCAN: begin
                if (!r_vld[ia]) begin
                    n_state = S_FREE_W;
                end else if (r_i == NIL - IW'(1)) begin
                    n_state = S_OUT;
                end else begin
                    n_i = r_i + IW'(1);
                end
            end
            S_FREE_W: begin
                // write key, flags, links; push at head
                km_we = 1'b1; km_addr = ia; km_wd = r_key;
                lm_we = 1'b1; lm_addr = ia; lm_wd = {NIL, r_head};
                n_vld[ia] = 1'b1; n_vis[ia] = 1'b0; n_srv[ia] = 1'b0;
                n_ec = r_ec + IW'(1);
                n_p = r_head; n_head = r_i;
                if (r_head == NIL) n_tail = r_i;
                n_state = S_INS;
            end
            S_INS: begin
                // read old head's links, if there is an old head
                if (r_p < NIL) begin
                    lm_addr = pa;
                    n_state = S_INS_W;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_INS_W: begin
                // old head now points toward the new head
                lm_we = 1'b1; lm_addr = pa; lm_wd = {r_i, rd_t};
                n_p = NIL;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (i_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_after <= K_NONE;
            r_head <= NIL; r_tail <= NIL; r_hand <= NIL;
            r_pc <= '0; r_hc <= '0; r_ec <= '0;
            r_vld <= '0; r_vis <= '0; r_srv <= '0;
            r_cap <= CAP_RESET;
        end else begin
            r_state <= n_state; r_after <= n_after;
            r_head <= n_head; r_tail <= n_tail; r_hand <= n_hand;
            r_pc <= n_pc; r_hc <= n_hc; r_ec <= n_ec;
            r_vld <= n_vld; r_vis <= n_vis; r_srv <= n_srv;
            if (i_cfg_valid && o_cfg_ready) r_cap <= i_capacity;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_op <= i_opcode; r_key <= i_key;
        end
        r_i <= n_i; r_lh <= n_lh; r_lt <= n_lt; r_p <= n_p;
        r_hit <= n_hit; r_ev <= n_ev; r_evk <= n_evk;
    end
endmodule

// ===== rtl/core/shec_checker.sv =====
// Port-level checker for the cache directory, bound to the top level.
`timescale 1ns / 1ps
module shec_checker
    import shec_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_valid,
    input logic             o_ready,
    input logic             o_valid,
    input logic             i_ready,
    input logic             o_hit,
    input logic             o_evicted,
    input logic [KEY_W-1:0] o_evicted_key
);
    // no new word is taken while a result waits
    a_one_at_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready) else $error("input taken while result pending");
    // an accepted word keeps the input closed on the next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready) else $error("input open right after accept");
    // a hit never evicts
    a_hit_no_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_hit |-> !o_evicted) else $error("hit with eviction");
    // no eviction reports zero key
    a_key_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_evicted |-> o_evicted_key == '0) else $error("stray evicted key");
    // result holds while stalled
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_evicted_key))
        else $error("result dropped");
endmodule

bind sieve_hand_eviction_cache shec_checker u_shec_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
    .o_valid(o_valid), .i_ready(i_ready), .o_hit(o_hit), .o_evicted(o_evicted),
    .o_evicted_key(o_evicted_key));

// ===== sim/tb_top.sv =====
// Testbench for the SIEVE-style cache directory: random traffic checked against a behavioral model.
`timescale 1ns / 1ps
module tb_top;
    import shec_pkg::*;

    localparam int NSLOT = 64;
    localparam int NIL = NSLOT;
    localparam int IDLE_LIMIT = 20000;

    typedef struct packed {
        logic             op;
        logic [KEY_W-1:0] key;
    } req_t;

    typedef struct packed {
        logic             hit;
        logic             evicted;
        logic [KEY_W-1:0] ev_key;
    } resp_t;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_cfg_valid = 1'b0;
    logic             o_cfg_ready;
    logic [CAP_W-1:0] i_capacity = '0;
    logic             i_valid = 1'b0;
    logic             o_ready;
    logic             i_opcode = OP_ACCESS;
    logic [KEY_W-1:0] i_key = '0;
    logic             o_valid;
    logic             i_ready = 1'b0;
    logic             o_hit;
    logic             o_evicted;
    logic [KEY_W-1:0] o_evicted_key;

    sieve_hand_eviction_cache DUT (
        .i_clk, .i_rst_n, .i_cfg_valid, .o_cfg_ready, .i_capacity,
        .i_valid, .o_ready, .i_opcode, .i_key,
        .o_valid, .i_ready, .o_hit, .o_evicted, .o_evicted_key
    );

    always #5 i_clk = ~i_clk;

    // Directory model state
    logic [KEY_W-1:0] m_key[NSLOT];
    bit               m_live[NSLOT];
    bit               m_vis[NSLOT];
    bit               m_surv[NSLOT];
    int               m_up[NSLOT];
    int               m_dn[NSLOT];
    int               m_head, m_tail, m_hand, m_passed, m_hot, m_count;
    int               m_cap;

    req_t  pending_reqs[$];
    resp_t expected_resps[$];
    int    errors = 0;
    bit    quiet = 1'b0;
    int    idle_cycles = 0;

    function automatic bit live(int i);
        return i < NSLOT && m_live[i];
    endfunction

    function automatic void unlink(int i);
        if (m_up[i] < NSLOT) m_dn[m_up[i]] = m_dn[i]; else m_head = m_dn[i];
        if (m_dn[i] < NSLOT) m_up[m_dn[i]] = m_up[i]; else m_tail = m_up[i];
    endfunction

    function automatic void to_head(int i);
        m_up[i] = NIL;
        m_dn[i] = m_head;
        if (m_head < NSLOT) m_up[m_head] = i; else m_tail = i;
        m_head = i;
    endfunction

    function automatic void drop(int i);
        unlink(i);
        m_live[i] = 0;
        m_vis[i] = 0;
        m_surv[i] = 0;
        if (m_count > 0) m_count--;
    endfunction

    // Hand walk: returns the victim slot or NIL
    function automatic int walk_victim();
        int p;
        p = m_hand;
        if (!live(p)) begin
            p = m_tail;
            m_passed = 0;
            m_hot = 0;
        end
        if (!live(p)) return NIL;
        while (m_vis[p]) begin
            m_vis[p] = 0;
            if (!m_surv[p]) begin
                m_surv[p] = 1;
                m_hot++;
            end
            p = m_up[p];
            m_passed++;
            if (m_passed >= m_count || m_count - m_passed <= m_hot / 2 || !live(p)) begin
                p = m_tail;
                m_passed = 0;
                m_hot = 0;
            end
        end
        m_hand = m_up[p];
        drop(p);
        return p;
    endfunction

    function automatic void dir_reset();
        foreach (m_live[i]) begin
            m_live[i] = 0;
            m_vis[i] = 0;
            m_surv[i] = 0;
            m_up[i] = NIL;
            m_dn[i] = NIL;
            m_key[i] = '0;
        end
        m_head = NIL;
        m_tail = NIL;
        m_hand = NIL;
        m_passed = 0;
        m_hot = 0;
        m_count = 0;
        m_cap = 64;
    endfunction

    function automatic resp_t dir_lookup(req_t r);
        resp_t o;
        int    idx, cap, v, f;
        bit    first;
        o = '0;
        idx = NIL;
        for (int i = 0; i < NSLOT; i++)
            if (idx == NIL && m_live[i] && m_key[i] == r.key) idx = i;
        cap = (m_cap < 1) ? 1 : (m_cap > NSLOT ? NSLOT : m_cap);
        if (r.op == OP_REMOVE) begin
            if (idx < NSLOT) begin
                if (m_hand == idx) m_hand = m_up[idx];
                drop(idx);
                o.hit = 1;
            end
            return o;
        end
        if (idx < NSLOT) begin
            if (!m_surv[idx]) begin
                if (m_hand == idx) m_hand = m_up[idx];
                unlink(idx);
                to_head(idx);
            end
            m_vis[idx] = 1;
            o.hit = 1;
            return o;
        end
        first = 1;
        while (m_count >= cap) begin
            v = walk_victim();
            if (v >= NSLOT) break;
            if (first) begin
                first = 0;
                o.evicted = 1;
                o.ev_key = m_key[v];
            end
        end
        f = NIL;
        for (int i = NSLOT - 1; i >= 0; i--)
            if (!m_live[i]) f = i;
        if (f < NSLOT) begin
            m_key[f] = r.key;
            m_live[f] = 1;
            m_vis[f] = 0;
            m_surv[f] = 0;
            to_head(f);
            m_count++;
        end
        return o;
    endfunction

    task automatic report(string what, logic [KEY_W-1:0] got, logic [KEY_W-1:0] want);
        $display("MISMATCH %s: got %0h want %0h at %0t", what, got, want, $time);
        errors++;
    endtask

    // Request driver
    int drv_gap = 0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                expected_resps.push_back(dir_lookup('{op: i_opcode, key: i_key}));
            end
            if (!i_valid || o_ready) begin
                if (drv_gap > 0) begin
                    drv_gap <= drv_gap - 1;
                    i_valid <= 1'b0;
                end else if (pending_reqs.size() > 0) begin
                    req_t r;
                    r = pending_reqs.pop_front();
                    i_valid <= 1'b1;
                    i_opcode <= r.op;
                    i_key <= r.key;
                    if (!quiet && $urandom_range(0, 9) == 0) drv_gap <= $urandom_range(1, 13);
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Response monitor
    int mon_gap = 0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                if (expected_resps.size() == 0) begin
                    report("unexpected word", o_evicted_key, '0);
                end else begin
                    resp_t e;
                    e = expected_resps.pop_front();
                    if (o_hit !== e.hit) report("hit", o_hit, e.hit);
                    if (o_evicted !== e.evicted) report("evicted", o_evicted, e.evicted);
                    if (o_evicted_key !== e.ev_key) report("evicted_key", o_evicted_key, e.ev_key);
                end
            end
            if (mon_gap > 0) begin
                mon_gap <= mon_gap - 1;
                i_ready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 9) == 0) begin
                // start a stall with this cycle; mon_gap holds the rest of it
                mon_gap <= $urandom_range(0, 12);
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    // Watchdog on cycles with no accepted word
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic logic [KEY_W-1:0] pick_key(int span);
        if ($urandom_range(0, 19) == 0) return $urandom();
        return 32'h1000 + $urandom_range(0, span - 1);
    endfunction

    task automatic add_req(logic op, logic [KEY_W-1:0] k);
        pending_reqs.push_back('{op: op, key: k});
    endtask

    task automatic drain();
        while (pending_reqs.size() > 0 || i_valid || expected_resps.size() > 0)
            @(posedge i_clk);
        repeat (300) @(posedge i_clk);
    endtask

    task automatic set_capacity(logic [CAP_W-1:0] c);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_capacity <= c;
        do @(posedge i_clk); while (!o_cfg_ready);
        m_cap = c;
        i_cfg_valid <= 1'b0;
    endtask

    // Random phase with a given capacity and key span
    task automatic run_phase(logic [CAP_W-1:0] c, int n, int span);
        set_capacity(c);
        for (int i = 0; i < n; i++)
            add_req(($urandom_range(0, 5) == 0) ? OP_REMOVE : OP_ACCESS, pick_key(span));
        drain();
    endtask

    initial begin
        dir_reset();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: extreme keys, hits, removes, eviction at capacity 2
        set_capacity(7'd2);
        add_req(OP_ACCESS, 32'h0);
        add_req(OP_ACCESS, 32'hFFFF_FFFF);
        add_req(OP_ACCESS, 32'h0);
        add_req(OP_ACCESS, 32'h0);
        add_req(OP_ACCESS, 32'hA5A5_5A5A);
        add_req(OP_ACCESS, 32'h5A5A_A5A5);
        add_req(OP_REMOVE, 32'h1234_5678);
        add_req(OP_REMOVE, 32'h5A5A_A5A5);
        add_req(OP_ACCESS, 32'hFFFF_FFFF);
        add_req(OP_ACCESS, 32'h7);
        add_req(OP_ACCESS, 32'h7);
        add_req(OP_ACCESS, 32'h8);
        add_req(OP_REMOVE, 32'h8);
        add_req(OP_REMOVE, 32'h7);
        drain();
        // Capacity zero acts as one; large value clamps; lowering below occupancy
        set_capacity(7'd127);
        for (int i = 0; i < 6; i++) add_req(OP_ACCESS, 32'h100 + i);
        drain();
        set_capacity(7'd0);
        add_req(OP_ACCESS, 32'h200);
        add_req(OP_ACCESS, 32'h200);
        add_req(OP_ACCESS, 32'h201);
        drain();

        run_phase(7'd64, 400, 90);
        run_phase(7'd1, 100, 4);
        run_phase(7'd8, 400, 14);
        run_phase(7'd127, 250, 80);
        run_phase(7'd3, 250, 8);
        run_phase(7'd32, 200, 50);
        quiet = 1'b1;
        run_phase(7'd16, 250, 24);

        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
